>>> rtl/core/bpfd_pkg.sv
// Package for the bounded packet FIFO with duplicate filter.
// Holds field widths, action codes, the packet, command and result types, the op enum and the state enum.
// No dependencies.
`default_nettype none

package bpfd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;

  localparam int unsigned SRC_W = 16;
  localparam int unsigned DST_W = 16;
  localparam int unsigned TS_W  = 31;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned CAP_W = 7;
  localparam int unsigned MCNT_W = 7;

  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
  localparam logic [MCNT_W-1:0] MCNT_MAX  = 7'h7F;

  // Action codes on the input port
  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FWD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CNT = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_FWD,
    OP_CNT,
    OP_NOP
  } op_e;

  typedef enum logic {
    B_IDLE,
    B_SCAN
  } back_state_e;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [DST_W-1:0] dst;
    logic [TS_W-1:0]  ts;
  } pkt_t;

  localparam int unsigned PKT_W = $bits(pkt_t);

  typedef struct packed {
    op_e             op;
    pkt_t            pkt;
    logic [TS_W-1:0] lo;
    logic [TS_W-1:0] hi;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic              added;
    logic              fwd_valid;
    pkt_t              pkt;
    logic [MCNT_W-1:0] count;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/bounded_packet_fifo_with_dedup.sv
// Top level of the bounded packet FIFO with duplicate filter.
// Depends on bpfd_pkg, bpfd_front, bpfd_back (and bpfd_ram through it).
`default_nettype none

// Packet FIFO of up to QueueDepth packets (source, destination, timestamp) with a
// duplicate filter. Issue an item with start while busy is low: action 0 adds a
// packet (refused, added_o = 0, if an identical packet is queued; if the queue is
// at capacity the oldest is dropped first), 1 forwards the oldest packet, 2 counts
// queued packets to a destination with timestamp in [start_time_i, end_time_i],
// saturating at 127. Every item gives exactly one result, shown for one cycle with
// result_valid_o; fields not produced by the action read zero. The result cannot
// be held off, so sample it when the strobe is high. Items go into a two-entry
// command queue, so busy only rises when two items are waiting. Each add and count
// walks the occupied entries of the packet RAM one per cycle; a forward reads only
// the oldest entry, and a forward on an empty queue or an undefined action reads
// none. The back end takes no new item until it has finished the last one. The
// capacity register (reset 64, 0 acts as 1, above QueueDepth acts as QueueDepth) is
// written through the cfg channel, always ready; write it only while no item is in
// flight. Lowering it below the current fill does not trim the queue: each accepted
// add then drops one packet only.
module bounded_packet_fifo_with_dedup
  import bpfd_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [SRC_W-1:0]  source_i,
  input  wire logic [DST_W-1:0]  destination_i,
  input  wire logic [TS_W-1:0]   timestamp_i,
  input  wire logic [TS_W-1:0]   start_time_i,
  input  wire logic [TS_W-1:0]   end_time_i,
  // result strobe and fields
  output logic                   result_valid_o,
  output logic                   added_o,
  output logic                   forward_valid_o,
  output logic [SRC_W-1:0]       out_source_o,
  output logic [DST_W-1:0]       out_destination_o,
  output logic [TS_W-1:0]        out_timestamp_o,
  output logic [MCNT_W-1:0]      match_count_o,
  // capacity register write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CAP_W-1:0]  cfg_data_i
);

  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  res_t             res;
  logic [CAP_W-1:0] capacity_q;

  // capacity register: always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  bpfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .source_i      (source_i),
    .destination_i (destination_i),
    .timestamp_i   (timestamp_i),
    .start_time_i  (start_time_i),
    .end_time_i    (end_time_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  bpfd_back #(
    .QueueDepth (QueueDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .capacity_i  (capacity_q),
    .res_o       (res)
  );

  // result register lives in the back end; fields are zero between strobes
  assign result_valid_o    = res.valid;
  assign added_o           = res.added;
  assign forward_valid_o   = res.fwd_valid;
  assign out_source_o      = res.pkt.src;
  assign out_destination_o = res.pkt.dst;
  assign out_timestamp_o   = res.pkt.ts;
  assign match_count_o     = res.count;

`ifndef SYNTH
  // one action's field per result
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $onehot0({added_o, forward_valid_o, match_count_o != '0}))
    else $error("result carries fields of more than one action");

  // empty or non-forward result carries no packet
  a_pkt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !forward_valid_o) |->
      (out_source_o == '0 && out_destination_o == '0 && out_timestamp_o == '0))
    else $error("packet fields set without a forwarded packet");

  // fields stay quiet without the strobe
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> (!added_o && !forward_valid_o && match_count_o == '0))
    else $error("result fields active without strobe");

  // back end returns to idle between items, so strobes never repeat back to back
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in consecutive cycles");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bpfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bpfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bpfd_front.sv
// Front end: takes items, decodes the action and holds them in a two-entry command queue.
// Depends on bpfd_pkg.
`default_nettype none

module bpfd_front
  import bpfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [ACT_W-1:0] action_i,
  input  wire logic [SRC_W-1:0] source_i,
  input  wire logic [DST_W-1:0] destination_i,
  input  wire logic [TS_W-1:0]  timestamp_i,
  input  wire logic [TS_W-1:0]  start_time_i,
  input  wire logic [TS_W-1:0]  end_time_i,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  input  wire logic             cmd_pop_i
);

  cmd_t       q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.pkt.src = source_i;
    cmd_in.pkt.dst = destination_i;
    cmd_in.pkt.ts  = timestamp_i;
    cmd_in.lo      = start_time_i;
    cmd_in.hi      = end_time_i;
    case (action_i)
      ACT_ADD: cmd_in.op = OP_ADD;
      ACT_FWD: cmd_in.op = OP_FWD;
      ACT_CNT: cmd_in.op = OP_CNT;
      default: cmd_in.op = OP_NOP;
    endcase
  end

  assign busy        = (cnt_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bpfd_back.sv
// Back end: ring buffer in RAM, scan sequencer for duplicate check and range count,
// add/forward bookkeeping and the result register.
// Depends on bpfd_pkg and bpfd_ram.
`default_nettype none

module bpfd_back
  import bpfd_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF,
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1,
  localparam int unsigned CntW = $clog2(QueueDepth + 1),
  localparam int unsigned CmpW = (CntW > CAP_W) ? CntW : CAP_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  wire logic [CAP_W-1:0] capacity_i,
  output res_t                  res_o
);

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   occ_q, occ_d, left_q, left_d;
  logic              rv_q, hit_q, hit_d;
  logic [MCNT_W-1:0] cnt_q, cnt_d;
  pkt_t              fwd_q, fwd_d;
  res_t              res_q, res_d;
  logic              rd_en, we, done, full;
  logic [CmpW-1:0]   cap_w, eff_cap;
  logic [PKT_W-1:0]  rdata_raw;
  pkt_t              rdata;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  bpfd_ram #(
    .Width (PKT_W),
    .Depth (QueueDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (cmd_q.pkt),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata_raw)
  );

  assign rdata = pkt_t'(rdata_raw);

  // Capacity 0 acts as 1, anything above the depth acts as the depth
  always_comb begin
    cap_w = CmpW'(capacity_i);
    if (cap_w == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_w > CmpW'(QueueDepth)) begin
      eff_cap = CmpW'(QueueDepth);
    end else begin
      eff_cap = cap_w;
    end
  end

  assign full = (CmpW'(occ_q) >= eff_cap);
  assign done = (state_q == B_SCAN) && (left_q == '0) && !rv_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (cmd_valid_i) state_d = B_SCAN;
      B_SCAN: if (done) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    we        = 1'b0;
    head_d    = head_q;
    tail_d    = tail_q;
    occ_d     = occ_q;
    rd_ptr_d  = rd_ptr_q;
    left_d    = left_q;
    hit_d     = hit_q;
    cnt_d     = cnt_q;
    fwd_d     = fwd_q;
    res_d     = '0;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          rd_ptr_d  = head_q;
          hit_d     = 1'b0;
          cnt_d     = '0;
          case (cmd_i.op)
            OP_ADD, OP_CNT: left_d = occ_q;
            OP_FWD:         left_d = (occ_q != '0) ? CntW'(1) : '0;
            default:        left_d = '0;
          endcase
        end
      end
      B_SCAN: begin
        rd_en = (left_q != '0);
        if (rd_en) begin
          rd_ptr_d = nxt(rd_ptr_q);
          left_d   = left_q - CntW'(1);
        end
        if (rv_q) begin
          case (cmd_q.op)
            OP_ADD: if (rdata == cmd_q.pkt) hit_d = 1'b1;
            OP_CNT: begin
              if (rdata.dst == cmd_q.pkt.dst && rdata.ts >= cmd_q.lo &&
                  rdata.ts <= cmd_q.hi && cnt_q != MCNT_MAX) begin
                cnt_d = cnt_q + MCNT_W'(1);
              end
            end
            OP_FWD: fwd_d = rdata;
            default: ;
          endcase
        end
        if (done) begin
          res_d.valid = 1'b1;
          case (cmd_q.op)
            OP_ADD: begin
              if (!hit_q) begin
                we          = 1'b1;
                tail_d      = nxt(tail_q);
                res_d.added = 1'b1;
                // at capacity: oldest goes out, count stays
                if (full) begin
                  head_d = nxt(head_q);
                end else begin
                  occ_d = occ_q + CntW'(1);
                end
              end
            end
            OP_FWD: begin
              if (occ_q != '0) begin
                res_d.fwd_valid = 1'b1;
                res_d.pkt       = fwd_q;
                head_d          = nxt(head_q);
                occ_d           = occ_q - CntW'(1);
              end
            end
            OP_CNT:  res_d.count = cnt_q;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    rd_ptr_q <= rd_ptr_d;
    hit_q    <= hit_d;
    cnt_q    <= cnt_d;
    fwd_q    <= fwd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      left_q  <= '0;
      rv_q    <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      left_q  <= left_d;
      rv_q    <= rd_en;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Testbench for bounded_packet_fifo_with_dedup: directed and random command items,
// an in-order scoreboard of predicted results and a sweep of capacity settings.
// Depends on bpfd_pkg and the RTL top level.
`default_nettype none

module tb_top;
  import bpfd_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;
  localparam logic [TS_W-1:0] TS_MAX = '1;
  localparam logic [SRC_W-1:0] ID_MAX = '1;
  localparam int unsigned RAND_PER_PHASE = 197;
  // Quiet time after the last result, waited out before each capacity write.
  localparam int unsigned SETTLE_CYCLES = DEPTH + 8;
  // Slowest legal quiet stretch: one add or count over a full queue behind a sender
  // gap (64 percent idle), or a drain plus the settle time and a capacity write.
  // The limit is many times that.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // One command item as the sender presents it
  typedef struct packed {
    logic [ACT_W-1:0] action;
    pkt_t             pkt;
    logic [TS_W-1:0]  lo;
    logic [TS_W-1:0]  hi;
  } cmd_item_t;

  // Fields of one result item
  typedef struct packed {
    logic              added;
    logic              fwd;
    pkt_t              pkt;
    logic [MCNT_W-1:0] count;
  } outcome_t;

  // Predicted result plus the cycle its command was taken
  typedef struct packed {
    outcome_t    res;
    logic [63:0] stamp;
  } awaited_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              start = 1'b0;
  logic              busy;
  logic [ACT_W-1:0]  action_i = '0;
  logic [SRC_W-1:0]  source_i = '0;
  logic [DST_W-1:0]  destination_i = '0;
  logic [TS_W-1:0]   timestamp_i = '0;
  logic [TS_W-1:0]   start_time_i = '0;
  logic [TS_W-1:0]   end_time_i = '0;
  logic              result_valid_o;
  logic              added_o;
  logic              forward_valid_o;
  logic [SRC_W-1:0]  out_source_o;
  logic [DST_W-1:0]  out_destination_o;
  logic [TS_W-1:0]   out_timestamp_o;
  logic [MCNT_W-1:0] match_count_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CAP_W-1:0]  cfg_data_i = '0;

  // Shadow of the queue contents and the capacity register
  pkt_t             fifo_model[$];
  logic [CAP_W-1:0] cap_model = CAP_RESET;

  cmd_item_t cmd_backlog[$];
  awaited_t  awaited_q[$];
  cmd_item_t cur_cmd;
  awaited_t  new_entry;
  awaited_t  got_entry;

  logic [63:0] cyc = '0;
  int unsigned idle_pct = 0;
  int unsigned errors = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned refused_adds = 0;
  int unsigned empty_fwds = 0;
  int unsigned cap_writes = 0;
  int unsigned watchdog = 0;

  always #10 clk_i = ~clk_i;

  bounded_packet_fifo_with_dedup #(
    .QueueDepth(DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .source_i         (source_i),
    .destination_i    (destination_i),
    .timestamp_i      (timestamp_i),
    .start_time_i     (start_time_i),
    .end_time_i       (end_time_i),
    .result_valid_o   (result_valid_o),
    .added_o          (added_o),
    .forward_valid_o  (forward_valid_o),
    .out_source_o     (out_source_o),
    .out_destination_o(out_destination_o),
    .out_timestamp_o  (out_timestamp_o),
    .match_count_o    (match_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // Applies one command to the shadow queue and returns the result it must give.
  function automatic outcome_t fifo_step(cmd_item_t c);
    outcome_t    o;
    bit          dup;
    int unsigned limit;
    int unsigned hits;
    o = '0;
    dup = 1'b0;
    hits = 0;
    // capacity 0 behaves as 1, anything above the depth as the depth
    limit = (cap_model == 0) ? 1 : (cap_model > DEPTH) ? DEPTH : int'(cap_model);
    case (c.action)
      ACT_ADD: begin
        // duplicate check runs over the queue before any eviction
        foreach (fifo_model[i]) begin
          if (fifo_model[i] == c.pkt) dup = 1'b1;
        end
        if (dup) begin
          refused_adds++;
        end else begin
          // only one packet is dropped, even if capacity was lowered below fill
          if (fifo_model.size() >= limit) void'(fifo_model.pop_front());
          fifo_model.push_back(c.pkt);
          o.added = 1'b1;
        end
      end
      ACT_FWD: begin
        if (fifo_model.size() != 0) begin
          o.fwd = 1'b1;
          o.pkt = fifo_model.pop_front();
        end else begin
          empty_fwds++;
        end
      end
      ACT_CNT: begin
        foreach (fifo_model[i]) begin
          if (fifo_model[i].dst == c.pkt.dst && fifo_model[i].ts >= c.lo &&
              fifo_model[i].ts <= c.hi && hits < MCNT_MAX) hits++;
        end
        o.count = hits[MCNT_W-1:0];
      end
      default: begin
        // undefined action: no state change, all-zero result
      end
    endcase
    return o;
  endfunction

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Ids: a tiny pool most of the time so duplicates and count hits are common.
  function automatic logic [SRC_W-1:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return SRC_W'($urandom_range(0, 3));
    if (sel < 80) return ID_MAX - SRC_W'($urandom_range(0, 1));
    return SRC_W'($urandom());
  endfunction

  function automatic logic [TS_W-1:0] pick_ts();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return TS_W'($urandom_range(0, 3));
    if (sel < 80) return TS_MAX - TS_W'($urandom_range(0, 1));
    return TS_W'($urandom());
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t   c;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) c.action = ACT_ADD;
    else if (sel < 74) c.action = ACT_FWD;
    else if (sel < 95) c.action = ACT_CNT;
    else c.action = ACT_UNDEF;
    c.pkt.src = pick_id();
    c.pkt.dst = pick_id();
    c.pkt.ts = pick_ts();
    if ($urandom_range(0, 99) < 30) begin
      c.lo = '0;
      c.hi = TS_MAX;
    end else begin
      // independent bounds, so empty and single-point ranges both occur
      c.lo = pick_ts();
      c.hi = pick_ts();
    end
    return c;
  endfunction

  function automatic void queue_cmd(logic [ACT_W-1:0] act, logic [SRC_W-1:0] s,
                                    logic [DST_W-1:0] d, logic [TS_W-1:0] t,
                                    logic [TS_W-1:0] lo, logic [TS_W-1:0] hi);
    cmd_item_t c;
    c.action = act;
    c.pkt.src = s;
    c.pkt.dst = d;
    c.pkt.ts = t;
    c.lo = lo;
    c.hi = hi;
    cmd_backlog.push_back(c);
  endfunction

  // Hold the sender off until every queued item is taken and every result is back.
  task automatic wait_drained();
    @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start || awaited_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cap_model = value;
    cap_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) cyc <= cyc + 1;

  // Driver: presents backlog items, holds each until start && !busy takes it,
  // and predicts its result at the edge it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      action_i <= '0;
      source_i <= '0;
      destination_i <= '0;
      timestamp_i <= '0;
      start_time_i <= '0;
      end_time_i <= '0;
    end else begin
      if (start && !busy) begin
        new_entry.res = fifo_step(cur_cmd);
        new_entry.stamp = cyc;
        awaited_q.push_back(new_entry);
        items_taken++;
      end
      // an item refused by busy stays on the port unchanged
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          start <= 1'b1;
          action_i <= cur_cmd.action;
          source_i <= cur_cmd.pkt.src;
          destination_i <= cur_cmd.pkt.dst;
          timestamp_i <= cur_cmd.pkt.ts;
          start_time_i <= cur_cmd.lo;
          end_time_i <= cur_cmd.hi;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  // A prediction stamped this cycle belongs to an item taken at this very edge
  // and cannot have a result yet.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (awaited_q.size() == 0 || awaited_q[0].stamp >= cyc) begin
        errors++;
        $display("%0t: unexpected result, expected none, got added %0b fwd %0b cnt %0d",
                 $time, added_o, forward_valid_o, match_count_o);
      end else begin
        got_entry = awaited_q.pop_front();
        compare_field("added", 64'(got_entry.res.added), 64'(added_o));
        compare_field("forward_valid", 64'(got_entry.res.fwd), 64'(forward_valid_o));
        compare_field("out_source", 64'(got_entry.res.pkt.src), 64'(out_source_o));
        compare_field("out_destination", 64'(got_entry.res.pkt.dst),
                      64'(out_destination_o));
        compare_field("out_timestamp", 64'(got_entry.res.pkt.ts), 64'(out_timestamp_o));
        compare_field("match_count", 64'(got_entry.res.count), 64'(match_count_o));
      end
    end
  end

  // Watchdog on cycles with no item taken, no result and no register write.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      watchdog <= 0;
    end else if (watchdog >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, watchdog, awaited_q.size());
      $display("tb_top failed");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  initial begin
    int unsigned cap_plan[8];
    int unsigned idle_plan[4];
    // 127 fills the queue to the depth; the 1 and 2 after it lower capacity
    // below the current fill
    cap_plan = '{0, 127, 1, 64, 2, 100, 17, 0};
    cap_plan[7] = $urandom_range(3, 126);
    // no idling, sender idle 64 percent, no idling, sender idle 12 percent
    idle_plan = '{0, 64, 0, 12};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset capacity
    @(negedge clk_i);
    idle_pct = 0;
    queue_cmd(ACT_CNT, '0, '0, '0, '0, TS_MAX);          // count on empty queue
    queue_cmd(ACT_FWD, '0, '0, '0, '0, '0);              // forward on empty queue
    queue_cmd(ACT_UNDEF, ID_MAX, ID_MAX, TS_MAX, TS_MAX, TS_MAX);
    queue_cmd(ACT_ADD, '0, '0, '0, '0, '0);
    queue_cmd(ACT_ADD, ID_MAX, ID_MAX, TS_MAX, '0, '0);
    queue_cmd(ACT_ADD, '0, '0, '0, TS_MAX, TS_MAX);      // duplicate, refused
    queue_cmd(ACT_ADD, ID_MAX, ID_MAX, '0, '0, '0);
    queue_cmd(ACT_ADD, '0, ID_MAX, TS_MAX, '0, '0);
    queue_cmd(ACT_CNT, '0, ID_MAX, '0, '0, TS_MAX);      // full range
    queue_cmd(ACT_CNT, '0, ID_MAX, '0, TS_MAX, TS_MAX);  // single point at top
    queue_cmd(ACT_CNT, '0, ID_MAX, '0, TS_MAX, '0);      // empty range
    queue_cmd(ACT_CNT, ID_MAX, '0, TS_MAX, '0, '0);
    queue_cmd(ACT_FWD, ID_MAX, ID_MAX, TS_MAX, TS_MAX, TS_MAX);
    queue_cmd(ACT_ADD, '0, '0, '0, '0, '0);              // no longer queued, accepted
    repeat (4) queue_cmd(ACT_FWD, '0, '0, '0, '0, '0);
    queue_cmd(ACT_FWD, '0, '0, '0, '0, '0);              // forward on the emptied queue
    queue_cmd(ACT_UNDEF, '0, '0, '0, '0, '0);
    wait_drained();

    // Random phases, one capacity setting each, drained before each write
    foreach (cap_plan[p]) begin
      write_capacity(CAP_W'(cap_plan[p]));
      @(negedge clk_i);
      idle_pct = idle_plan[p % 4];
      if (cap_plan[p] == 1) begin
        // an add and its duplicate at capacity 1, then an evicting add
        queue_cmd(ACT_ADD, 16'd1, 16'd2, 31'd3, '0, '0);
        queue_cmd(ACT_ADD, 16'd1, 16'd2, 31'd3, '0, '0);
        queue_cmd(ACT_ADD, 16'd1, 16'd2, 31'd4, '0, '0);
        queue_cmd(ACT_CNT, '0, 16'd2, '0, '0, TS_MAX);
        queue_cmd(ACT_FWD, '0, '0, '0, '0, '0);
      end
      repeat (RAND_PER_PHASE) cmd_backlog.push_back(rand_cmd());
      wait_drained();
    end

    $display("Ran %0d items, checked %0d results over %0d capacity writes.",
             items_taken, results_seen, cap_writes);
    $display("Refused duplicate adds: %0d, forwards on empty queue: %0d.",
             refused_adds, empty_fwds);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
